### hw/rtl/lkt_pkg.sv
package lkt_pkg;

   localparam int KEY_W      = 64;
   localparam int SIZE_W     = 20;
   localparam int COUNT_W    = 7;
   localparam int RANK_W     = 6;
   localparam int KIND_W     = 3;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 96;

   localparam logic [KEY_W-1:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;

   localparam logic REQ_TOUCH = 1'b0;
   localparam logic REQ_EVICT = 1'b1;

   localparam logic [KIND_W-1:0] KIND_HIT    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FULL   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EVICT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NONE   = 3'd4;

   typedef struct packed {
      logic              capture;
      logic              hash_a;
      logic              hash_b;
      logic              match;
      logic              touch_update;
      logic              ev_find;
      logic              ev_remove;
      logic              load_out;
      logic [KIND_W-1:0] kind;
      logic              last;
   } ctl_type;

   typedef struct packed {
      logic hit;
      logic can_insert;
      logic evict_more;
      logic last_evict;
   } sts_type;

endpackage

### hw/rtl/lru_key_table_with_eviction_top.sv
// LRU key table of up to CAPACITY entries. A touch hashes key and fft_size,
// looks the hash up in all slots at once, then moves a hit to most recent or
// inserts a new entry (refused when full); it returns one response after the
// 64-bit hash adder steps, the parallel match and the rank update, which waits
// while the output register is still held. An evict returns one response per
// removed entry, each after a victim rank search with key/size memory read and
// then the removal, or a single "nothing evicted" response. One request is
// worked on at a time; a new one is taken as soon as the previous response
// sits in the output register.
module lru_key_table_with_eviction_top
   import lkt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // key, fft_size, max_entries
   input  logic [0:0]            req_tuser,  // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_key, out_fft_size, entry_count
   output logic [KIND_W-1:0]     rsp_tuser,  // kind
   output logic                  rsp_tlast
);

   ctl_type            ctl;
   sts_type            sts;
   logic [KEY_W-1:0]   out_key;
   logic [SIZE_W-1:0]  out_size;
   logic [COUNT_W-1:0] out_count;

   lkt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser[0]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .ctl        (ctl),
      .sts        (sts)
   );

   lkt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .in_key    (req_tdata[KEY_W-1:0]),
      .in_size   (req_tdata[KEY_W+SIZE_W-1:KEY_W]),
      .in_keep   (req_tdata[KEY_W+SIZE_W+COUNT_W-1:KEY_W+SIZE_W]),
      .out_kind  (rsp_tuser),
      .out_key   (out_key),
      .out_size  (out_size),
      .out_count (out_count),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_W-KEY_W-SIZE_W-COUNT_W){1'b0}}, out_count, out_size, out_key};

endmodule

### hw/rtl/lkt_ctrl.sv
module lkt_ctrl
   import lkt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    req_cmd,
   input  logic    rsp_tready,
   output logic    rsp_tvalid,
   output ctl_type ctl,
   input  sts_type sts
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_HASH_A   = 3'd1;
   localparam logic [2:0] S_HASH_B   = 3'd2;
   localparam logic [2:0] S_MATCH    = 3'd3;
   localparam logic [2:0] S_TOUCH    = 3'd4;
   localparam logic [2:0] S_EV_CHECK = 3'd5;
   localparam logic [2:0] S_EV_EMIT  = 3'd6;
   localparam logic [2:0] S_NONE     = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               state_in    = (req_cmd == REQ_EVICT) ? S_EV_CHECK : S_HASH_A;
            end
         end
         S_HASH_A: begin
            ctl.hash_a = 1'b1;
            state_in   = S_HASH_B;
         end
         S_HASH_B: begin
            ctl.hash_b = 1'b1;
            state_in   = S_MATCH;
         end
         S_MATCH: begin
            ctl.match = 1'b1;
            state_in  = S_TOUCH;
         end
         S_TOUCH: begin
            if (out_free) begin
               ctl.touch_update = 1'b1;
               ctl.load_out     = 1'b1;
               ctl.last         = 1'b1;
               if (sts.hit) begin
                  ctl.kind = KIND_HIT;
               end else if (sts.can_insert) begin
                  ctl.kind = KIND_INSERT;
               end else begin
                  ctl.kind = KIND_FULL;
               end
               state_in = S_IDLE;
            end
         end
         S_EV_CHECK: begin
            ctl.ev_find = 1'b1;
            state_in    = sts.evict_more ? S_EV_EMIT : S_NONE;
         end
         S_EV_EMIT: begin
            if (out_free) begin
               ctl.ev_remove = 1'b1;
               ctl.load_out  = 1'b1;
               ctl.kind      = KIND_EVICT;
               ctl.last      = sts.last_evict;
               state_in      = sts.last_evict ? S_IDLE : S_EV_CHECK;
            end
         end
         S_NONE: begin
            if (out_free) begin
               ctl.load_out = 1'b1;
               ctl.kind     = KIND_NONE;
               ctl.last     = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      if (ctl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hw/rtl/lkt_datapath.sv
module lkt_datapath
   import lkt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   output sts_type            sts,
   input  logic [KEY_W-1:0]   in_key,
   input  logic [SIZE_W-1:0]  in_size,
   input  logic [COUNT_W-1:0] in_keep,
   output logic [KIND_W-1:0]  out_kind,
   output logic [KEY_W-1:0]   out_key,
   output logic [SIZE_W-1:0]  out_size,
   output logic [COUNT_W-1:0] out_count,
   output logic               out_last
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [KEY_W-1:0]    key_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [COUNT_W-1:0]  keep_ff;
   logic [KEY_W-1:0]    sum_ff;
   logic [KEY_W-1:0]    sum_in;
   logic [KEY_W-1:0]    lookup_ff;
   logic [KEY_W-1:0]    lookup_in;

   logic [KEY_W-1:0]    tab_hash_ff [CAPACITY];
   logic [RANK_W-1:0]   rank_ff     [CAPACITY];
   logic [RANK_W-1:0]   rank_in     [CAPACITY];
   logic [CAPACITY-1:0] valid_ff;
   logic [CAPACITY-1:0] valid_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;

   logic [KEY_W-1:0]    key_mem  [CAPACITY];
   logic [SIZE_W-1:0]   size_mem [CAPACITY];
   logic [KEY_W-1:0]    rd_key_ff;
   logic [SIZE_W-1:0]   rd_size_ff;

   logic                hit_ff;
   logic [IDX_W-1:0]    hit_idx_ff;
   logic [RANK_W-1:0]   hit_rank_ff;
   logic                free_ok_ff;
   logic [IDX_W-1:0]    free_idx_ff;
   logic [IDX_W-1:0]    victim_idx_ff;

   logic                hit_c;
   logic [IDX_W-1:0]    hit_idx_c;
   logic [RANK_W-1:0]   hit_rank_c;
   logic                free_c;
   logic [IDX_W-1:0]    free_idx_c;
   logic [IDX_W-1:0]    victim_idx_c;
   logic [RANK_W-1:0]   rank_want;
   logic                can_insert;
   logic                do_hit;
   logic                do_insert;

   logic [KIND_W-1:0]   out_kind_ff;
   logic [KEY_W-1:0]    out_key_ff;
   logic [SIZE_W-1:0]   out_size_ff;
   logic [COUNT_W-1:0]  out_count_ff;
   logic                out_last_ff;

   assign sum_in    = (key_ff << 6) + (key_ff >> 2);
   assign lookup_in = key_ff ^ (sum_ff + KEY_W'(size_ff) + GOLDEN);
   assign rank_want = RANK_W'(count_ff - COUNT_W'(1));

   assign can_insert = free_ok_ff && (count_ff < COUNT_W'(CAPACITY));
   assign do_hit     = ctl.touch_update && hit_ff;
   assign do_insert  = ctl.touch_update && !hit_ff && can_insert;

   assign sts.hit        = hit_ff;
   assign sts.can_insert = can_insert;
   assign sts.evict_more = count_ff > keep_ff;
   assign sts.last_evict = (count_ff - COUNT_W'(1)) <= keep_ff;

   // lowest-numbered slot wins in every search
   always_comb begin
      hit_c        = 1'b0;
      hit_idx_c    = '0;
      hit_rank_c   = '0;
      free_c       = 1'b0;
      free_idx_c   = '0;
      victim_idx_c = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tab_hash_ff[i] == lookup_ff)) begin
            hit_c      = 1'b1;
            hit_idx_c  = IDX_W'(i);
            hit_rank_c = rank_ff[i];
         end
         if (!valid_ff[i]) begin
            free_c     = 1'b1;
            free_idx_c = IDX_W'(i);
         end
         if (valid_ff[i] && (rank_ff[i] == rank_want)) begin
            victim_idx_c = IDX_W'(i);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int j = 0; j < CAPACITY; j++) begin
         rank_in[j] = rank_ff[j];
         if (do_hit) begin
            if (valid_ff[j] && (rank_ff[j] < hit_rank_ff)) begin
               rank_in[j] = rank_ff[j] + RANK_W'(1);
            end
            if (IDX_W'(j) == hit_idx_ff) begin
               rank_in[j] = '0;
            end
         end
         if (do_insert) begin
            if (valid_ff[j]) begin
               rank_in[j] = rank_ff[j] + RANK_W'(1);
            end
            if (IDX_W'(j) == free_idx_ff) begin
               rank_in[j]  = '0;
               valid_in[j] = 1'b1;
            end
         end
         if (ctl.ev_remove && (IDX_W'(j) == victim_idx_ff)) begin
            valid_in[j] = 1'b0;
         end
      end
      if (do_insert) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctl.ev_remove) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < CAPACITY; j++) begin
         rank_ff[j] <= rank_in[j];
         if (do_insert && (IDX_W'(j) == free_idx_ff)) begin
            tab_hash_ff[j] <= lookup_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         key_ff  <= in_key;
         size_ff <= in_size;
         keep_ff <= in_keep;
      end
      if (ctl.hash_a) begin
         sum_ff <= sum_in;
      end
      if (ctl.hash_b) begin
         lookup_ff <= lookup_in;
      end
      if (ctl.match) begin
         hit_ff      <= hit_c;
         hit_idx_ff  <= hit_idx_c;
         hit_rank_ff <= hit_rank_c;
         free_ok_ff  <= free_c;
         free_idx_ff <= free_idx_c;
      end
      if (ctl.ev_find) begin
         victim_idx_ff <= victim_idx_c;
      end
   end

   always_ff @(posedge clock) begin
      if (do_hit) begin
         key_mem[hit_idx_ff] <= key_ff;
      end else if (do_insert) begin
         key_mem[free_idx_ff] <= key_ff;
      end
      if (ctl.ev_find) begin
         rd_key_ff <= key_mem[victim_idx_c];
      end
   end

   always_ff @(posedge clock) begin
      if (do_insert) begin
         size_mem[free_idx_ff] <= size_ff;
      end
      if (ctl.ev_find) begin
         rd_size_ff <= size_mem[victim_idx_c];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         out_kind_ff  <= ctl.kind;
         out_key_ff   <= (ctl.kind == KIND_EVICT) ? rd_key_ff : '0;
         out_size_ff  <= (ctl.kind == KIND_EVICT) ? rd_size_ff : '0;
         out_count_ff <= count_in;
         out_last_ff  <= ctl.last;
      end
   end

   assign out_kind  = out_kind_ff;
   assign out_key   = out_key_ff;
   assign out_size  = out_size_ff;
   assign out_count = out_count_ff;
   assign out_last  = out_last_ff;

endmodule

### hw/rtl/lkt_checker.sv
module lkt_checker
   import lkt_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [KIND_W-1:0]     rsp_tuser,
   input logic                  rsp_tlast
);

   // stalled transaction holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_EVICT) |-> rsp_tlast)
      else $error("non-evict response without last");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_EVICT) |-> (rsp_tdata[KEY_W+SIZE_W-1:0] == '0))
      else $error("non-evict response carries key or size");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[KEY_W+SIZE_W+COUNT_W-1:KEY_W+SIZE_W] <= COUNT_W'(CAPACITY)))
      else $error("entry count above capacity");

endmodule

bind lru_key_table_with_eviction_top lkt_checker #(.CAPACITY(CAPACITY)) u_lkt_checker (.*);
